FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// Lottery slot picker package
// Field widths, status codes and register indexes of the slot picker.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int MODE_W    = 1;
   localparam int SLOT_W    = 6;
   localparam int IN_TICK_W = 8;
   localparam int RAND_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int WINNER_W  = 6;
   localparam int OSUM_W    = 14;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;
   localparam int DIV_CNT_W = $clog2(RAND_W);

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_TICK = 2'd1;
   localparam status_type STATUS_NONE_RUN = 2'd2;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_DRAW  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_TICKETS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TICKETS = 1'd1;

   localparam logic [CSR_DAT_W-1:0] MIN_TICKETS_RESET = 8'd1;
   localparam logic [CSR_DAT_W-1:0] MAX_TICKETS_RESET = 8'd255;

   localparam logic [OSUM_W-1:0] SUM_MAX = 14'h3FFF;

endpackage

FILE: hw/rtl/lottery_slot_picker_top.sv
// ----------------------------------------------------------------------------
// Lottery slot picker
// Weighted random pick over a table of slots held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   mode slot runnable tickets random_word
//  rsp       out        rsp_valid / rsp_ready   status winner ticket_sum
//  csr       in         csr_write_enable        csr_index csr_wdata
//
// In a draw, one memory read port scans the table once to sum tickets; unless that sum is
// zero, a radix-2 divider then works out the remainder bit by bit and a second scan stops
// at the winner.
// After reset a clearing pass writes every slot before req_ready rises.
// A result waits in the output register while the next item is taken in.
module lottery_slot_picker_top #(
   parameter int SLOTS       = 64,
   parameter int TICKET_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsp_pkg::MODE_W-1:0]          req_mode,
   input  logic [lsp_pkg::SLOT_W-1:0]          req_slot,
   input  logic                                req_runnable,
   input  logic [lsp_pkg::IN_TICK_W-1:0]       req_tickets,
   input  logic [lsp_pkg::RAND_W-1:0]          req_random_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lsp_pkg::status_type                 rsp_status,
   output logic [lsp_pkg::WINNER_W-1:0]        rsp_winner,
   output logic [lsp_pkg::OSUM_W-1:0]          rsp_ticket_sum,
   input  logic                                csr_write_enable,
   input  logic [lsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsp_pkg::CSR_DAT_W-1:0]       csr_wdata
);

`include "assert_macros.svh"

   localparam int IDX_W      = $clog2(SLOTS);
   localparam int SUM_W      = IDX_W + TICKET_BITS;
   localparam int ENT_W      = TICKET_BITS + 1;
   localparam int SLOT_EXT_W = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;
   localparam int WIN_EXT_W  = (IDX_W > lsp_pkg::WINNER_W) ? IDX_W : lsp_pkg::WINNER_W;
   localparam int TICK_EXT_W = (TICKET_BITS > lsp_pkg::IN_TICK_W) ? TICKET_BITS
                                                                  : lsp_pkg::IN_TICK_W;
   localparam int SUM_EXT_W  = (SUM_W > lsp_pkg::OSUM_W + 1) ? SUM_W : lsp_pkg::OSUM_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [lsp_pkg::DIV_CNT_W-1:0] LAST_STEP =
      lsp_pkg::DIV_CNT_W'(lsp_pkg::RAND_W - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_PICK  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [ENT_W-1:0] mem [SLOTS];

   logic [2:0]                         state_ff, state_in;
   logic [IDX_W-1:0]                   addr_ff, addr_in;
   logic                               scan_on_ff, scan_on_in;
   logic                               rd_vld_ff;
   logic [IDX_W-1:0]                   rd_idx_ff;
   logic [ENT_W-1:0]                   rd_data_ff;
   logic [SUM_W-1:0]                   sum_ff, sum_in;
   logic [SUM_W-1:0]                   acc_ff, acc_in;
   logic [SUM_W-1:0]                   rem_ff, rem_in;
   logic [lsp_pkg::RAND_W-1:0]         rnd_ff, rnd_in;
   logic [lsp_pkg::DIV_CNT_W-1:0]      step_ff, step_in;
   lsp_pkg::status_type                res_status_ff, res_status_in;
   logic [lsp_pkg::WINNER_W-1:0]       res_winner_ff, res_winner_in;
   logic [lsp_pkg::CSR_DAT_W-1:0]      min_ff, max_ff;
   logic                               rsp_valid_ff;
   lsp_pkg::status_type                rsp_status_ff;
   logic [lsp_pkg::WINNER_W-1:0]       rsp_winner_ff;
   logic [lsp_pkg::OSUM_W-1:0]         rsp_sum_ff;

   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_waddr;
   logic [ENT_W-1:0]                   mem_wdata;
   logic                               accept;
   logic                               rsp_load;
   logic                               tick_ok;
   logic [SLOT_EXT_W-1:0]              slot_ext;
   logic [TICK_EXT_W-1:0]              tick_ext;
   logic [WIN_EXT_W-1:0]               win_ext;
   logic [SUM_EXT_W-1:0]               sum_ext;
   logic [lsp_pkg::OSUM_W-1:0]         sum_sat;
   logic                               rd_run;
   logic [TICKET_BITS-1:0]             rd_tick;
   logic [SUM_W-1:0]                   rd_tick_ext;
   logic [SUM_W:0]                     shifted;
   logic [SUM_W:0]                     diff;
   logic                               found;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign slot_ext    = SLOT_EXT_W'(req_slot);
   assign tick_ext    = TICK_EXT_W'(req_tickets);
   assign tick_ok     = (req_tickets >= min_ff) && (req_tickets <= max_ff);
   assign rd_run      = rd_data_ff[ENT_W-1];
   assign rd_tick     = rd_data_ff[TICKET_BITS-1:0];
   assign rd_tick_ext = rd_run ? SUM_W'(rd_tick) : '0;
   assign win_ext     = WIN_EXT_W'(rd_idx_ff);
   assign sum_ext     = SUM_EXT_W'(sum_ff);
   assign sum_sat     = (sum_ext > SUM_EXT_W'(lsp_pkg::SUM_MAX)) ? lsp_pkg::SUM_MAX
                                                                : sum_ext[lsp_pkg::OSUM_W-1:0];
   assign shifted     = {rem_ff, rnd_ff[lsp_pkg::RAND_W-1]};
   assign diff        = shifted - {1'b0, sum_ff};
   assign found       = (state_ff == ST_PICK) && rd_vld_ff && rd_run
                        && ((acc_ff + rd_tick_ext) > rem_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (accept && (req_mode == lsp_pkg::MODE_WRITE) && tick_ok
                   && (slot_ext < SLOT_EXT_W'(SLOTS))) begin
         mem_we    = 1'b1;
         mem_waddr = slot_ext[IDX_W-1:0];
         mem_wdata = {req_runnable, tick_ext[TICKET_BITS-1:0]};
      end else if (found) begin
         mem_we    = 1'b1;
         mem_waddr = rd_idx_ff;
         mem_wdata = {1'b0, rd_tick};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      scan_on_in    = 1'b0;
      sum_in        = sum_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      rnd_in        = rnd_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_winner_in = res_winner_ff;

      if ((state_ff == ST_SUM) || (state_ff == ST_PICK)) begin
         scan_on_in = scan_on_ff && (addr_ff != LAST_IDX);
         if (scan_on_ff) begin
            addr_in = addr_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               addr_in       = '0;
               sum_in        = '0;
               rnd_in        = req_random_word;
               res_status_in = lsp_pkg::STATUS_OK;
               res_winner_in = '0;
               if (req_mode == lsp_pkg::MODE_DRAW) begin
                  scan_on_in = 1'b1;
                  state_in   = ST_SUM;
               end else begin
                  if (!tick_ok) begin
                     res_status_in = lsp_pkg::STATUS_BAD_TICK;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            if (rd_vld_ff) begin
               sum_in = sum_ff + rd_tick_ext;
               if (rd_idx_ff == LAST_IDX) begin
                  rem_in  = '0;
                  step_in = '0;
                  if (sum_in == '0) begin
                     res_status_in = lsp_pkg::STATUS_NONE_RUN;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = (shifted >= {1'b0, sum_ff}) ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
            rnd_in  = rnd_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               addr_in    = '0;
               acc_in     = '0;
               scan_on_in = 1'b1;
               state_in   = ST_PICK;
            end
         end
         ST_PICK: begin
            if (rd_vld_ff) begin
               acc_in = acc_ff + rd_tick_ext;
               if (found) begin
                  res_winner_in = win_ext[lsp_pkg::WINNER_W-1:0];
                  scan_on_in    = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         scan_on_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= lsp_pkg::MIN_TICKETS_RESET;
         max_ff       <= lsp_pkg::MAX_TICKETS_RESET;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         scan_on_ff <= scan_on_in;
         rd_vld_ff  <= scan_on_ff && ((state_ff == ST_SUM) || (state_ff == ST_PICK));
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               lsp_pkg::REG_MIN_TICKETS: min_ff <= csr_wdata;
               lsp_pkg::REG_MAX_TICKETS: max_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      rnd_ff        <= rnd_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_winner_ff <= res_winner_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_winner_ff <= res_winner_ff;
         rsp_sum_ff    <= sum_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_winner     = rsp_winner_ff;
   assign rsp_ticket_sum = rsp_sum_ff;

   // The remainder stays below the ticket sum for the whole division.
   `ASSERT_CLK(a_rem_below_sum, clock, reset,
      (state_ff == ST_DIV) |-> (rem_ff < sum_ff), "remainder not below ticket sum")
   // The table is not written while a draw sums or divides.
   `ASSERT_CLK(a_no_write_in_draw, clock, reset,
      ((state_ff == ST_SUM) || (state_ff == ST_DIV)) |-> !mem_we, "table written mid-draw")
   // A draw that finds nothing runnable reports a zero sum.
   `ASSERT_CLK(a_none_run_zero_sum, clock, reset,
      (rsp_valid && (rsp_status == lsp_pkg::STATUS_NONE_RUN)) |-> (rsp_ticket_sum == '0),
      "none runnable with nonzero sum")
   // The clearing pass keeps the input closed right after reset.
   `ASSERT_ALWAYS(a_closed_after_reset, clock,
      reset |=> !req_ready, "input open during clearing pass")

endmodule

FILE: bench/lottery_slot_picker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery slot picker testbench
// Drives slot writes and draws through the request channel and keeps its own
// copy of the ticket table and thresholds to predict every status, winner and
// ticket sum. The result channel is checked transfer by transfer in order,
// with random stalls on both sides and several threshold settings.
// ----------------------------------------------------------------------------
module lottery_slot_picker_top_test;

   localparam int          CLOCK_PERIOD = 4;
   localparam int          SLOT_COUNT   = 64;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   typedef struct packed {
      lsp_pkg::status_type            status;
      logic [lsp_pkg::WINNER_W-1:0]   winner;
      logic [lsp_pkg::OSUM_W-1:0]     ticket_sum;
   } pick_result_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [lsp_pkg::MODE_W-1:0]     req_mode         = lsp_pkg::MODE_WRITE;
   logic [lsp_pkg::SLOT_W-1:0]     req_slot         = '0;
   logic                           req_runnable     = 1'b0;
   logic [lsp_pkg::IN_TICK_W-1:0]  req_tickets      = '0;
   logic [lsp_pkg::RAND_W-1:0]     req_random_word  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   lsp_pkg::status_type            rsp_status;
   logic [lsp_pkg::WINNER_W-1:0]   rsp_winner;
   logic [lsp_pkg::OSUM_W-1:0]     rsp_ticket_sum;
   logic                           csr_write_enable = 1'b0;
   logic [lsp_pkg::CSR_IDX_W-1:0]  csr_index        = lsp_pkg::REG_MIN_TICKETS;
   logic [lsp_pkg::CSR_DAT_W-1:0]  csr_wdata        = '0;

   logic [lsp_pkg::IN_TICK_W-1:0]  slot_tickets [SLOT_COUNT];
   logic                           slot_runnable [SLOT_COUNT];
   logic [lsp_pkg::CSR_DAT_W-1:0]  min_tickets_cfg = lsp_pkg::MIN_TICKETS_RESET;
   logic [lsp_pkg::CSR_DAT_W-1:0]  max_tickets_cfg = lsp_pkg::MAX_TICKETS_RESET;

   pick_result_type       pending_picks [$];
   bit                    idling_on      = 1'b1;
   int unsigned           rsp_stall_left = 0;
   int unsigned           cycle_count    = 0;
   int unsigned           mismatch_count = 0;
   int unsigned           accepted_writes = 0;
   int unsigned           rejected_writes = 0;
   int unsigned           draw_count      = 0;
   int unsigned           winner_count    = 0;
   int unsigned           empty_draws     = 0;

   lottery_slot_picker_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_runnable     (req_runnable),
      .req_tickets      (req_tickets),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_winner       (rsp_winner),
      .rsp_ticket_sum   (rsp_ticket_sum),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      for (int idx = 0; idx < SLOT_COUNT; idx++) begin
         slot_tickets[idx]  = '0;
         slot_runnable[idx] = 1'b0;
      end
   end

   function automatic pick_result_type predict_slot_pick(
      input logic [lsp_pkg::MODE_W-1:0]    mode,
      input logic [lsp_pkg::SLOT_W-1:0]    slot,
      input logic                          run,
      input logic [lsp_pkg::IN_TICK_W-1:0] tick,
      input logic [lsp_pkg::RAND_W-1:0]    rnd
   );
      pick_result_type res;
      int unsigned     total;
      int unsigned     acc;
      int unsigned     draw_point;
      int              idx;
      res = '0;
      if (mode == lsp_pkg::MODE_WRITE) begin
         if (tick < min_tickets_cfg || tick > max_tickets_cfg) begin
            res.status = lsp_pkg::STATUS_BAD_TICK;
            rejected_writes++;
         end else begin
            slot_tickets[slot]  = tick;
            slot_runnable[slot] = run;
            accepted_writes++;
         end
      end else begin
         draw_count++;
         total = 0;
         for (idx = 0; idx < SLOT_COUNT; idx++) begin
            if (slot_runnable[idx]) begin
               total += slot_tickets[idx];
            end
         end
         res.ticket_sum = (total > lsp_pkg::SUM_MAX) ? lsp_pkg::SUM_MAX
                                                     : total[lsp_pkg::OSUM_W-1:0];
         if (total == 0) begin
            res.status = lsp_pkg::STATUS_NONE_RUN;
            empty_draws++;
         end else begin
            draw_point = rnd % total;
            acc = 0;
            for (idx = 0; idx < SLOT_COUNT; idx++) begin
               if (slot_runnable[idx]) begin
                  acc += slot_tickets[idx];
                  if (acc > draw_point) begin
                     res.winner = idx[lsp_pkg::WINNER_W-1:0];
                     slot_runnable[idx] = 1'b0;
                     winner_count++;
                     break;
                  end
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_picks.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_stall_left <= $urandom_range(0, 12);
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      pick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            $error("result transfer with nothing outstanding");
            mismatch_count++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_winner !== want.winner) begin
               $error("winner: expected %0d, got %0d", want.winner, rsp_winner);
               mismatch_count++;
            end
            if (rsp_ticket_sum !== want.ticket_sum) begin
               $error("ticket_sum: expected %0d, got %0d", want.ticket_sum, rsp_ticket_sum);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_item(
      input logic [lsp_pkg::MODE_W-1:0]    mode,
      input logic [lsp_pkg::SLOT_W-1:0]    slot,
      input logic                          run,
      input logic [lsp_pkg::IN_TICK_W-1:0] tick,
      input logic [lsp_pkg::RAND_W-1:0]    rnd
   );
      int unsigned gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_slot        <= slot;
      req_runnable    <= run;
      req_tickets     <= tick;
      req_random_word <= rnd;
      do @(posedge clock); while (!req_ready);
      pending_picks.push_back(predict_slot_pick(mode, slot, run, tick, rnd));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_thresholds(
      input logic [lsp_pkg::CSR_DAT_W-1:0] lo,
      input logic [lsp_pkg::CSR_DAT_W-1:0] hi
   );
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= lsp_pkg::REG_MIN_TICKETS;
      csr_wdata        <= lo;
      @(posedge clock);
      csr_index        <= lsp_pkg::REG_MAX_TICKETS;
      csr_wdata        <= hi;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      min_tickets_cfg = lo;
      max_tickets_cfg = hi;
   endtask

   task automatic send_random_item();
      logic [lsp_pkg::MODE_W-1:0]    mode;
      logic [lsp_pkg::SLOT_W-1:0]    slot;
      logic                          run;
      logic [lsp_pkg::IN_TICK_W-1:0] tick;
      logic [lsp_pkg::RAND_W-1:0]    rnd;
      int unsigned                   pick;
      int unsigned                   roll;
      mode = ($urandom_range(0, 99) < 40) ? lsp_pkg::MODE_DRAW : lsp_pkg::MODE_WRITE;
      roll = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
      slot = roll[lsp_pkg::SLOT_W-1:0];
      run  = ($urandom_range(0, 99) < 80);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         tick = min_tickets_cfg;
      end else if (pick < 20) begin
         tick = max_tickets_cfg;
      end else if (pick < 85) begin
         roll = $urandom_range(max_tickets_cfg, min_tickets_cfg);
         tick = roll[lsp_pkg::IN_TICK_W-1:0];
      end else begin
         roll = $urandom_range(0, 255);
         tick = roll[lsp_pkg::IN_TICK_W-1:0];
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         rnd = '0;
      end else if (pick == 1) begin
         rnd = '1;
      end else if (pick < 5) begin
         rnd = $urandom_range(0, 400);
      end else begin
         rnd = $urandom();
      end
      send_item(mode, slot, run, tick, rnd);
   endtask

   task automatic run_random_phase(
      input logic [lsp_pkg::CSR_DAT_W-1:0] lo,
      input logic [lsp_pkg::CSR_DAT_W-1:0] hi,
      input int unsigned                   count
   );
      wait_until_drained();
      write_thresholds(lo, hi);
      repeat (count) begin
         send_random_item();
         if ($urandom_range(0, 99) == 0) begin
            wait_until_drained();
         end
      end
   endtask

   task automatic test_empty_table();
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'd0);
      send_item(lsp_pkg::MODE_DRAW, 6'd63, 1'b1, 8'd255, 32'hFFFF_FFFF);
   endtask

   task automatic test_ticket_bounds();
      send_item(lsp_pkg::MODE_WRITE, 6'd0, 1'b1, 8'd0, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd0, 1'b1, 8'd1, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd63, 1'b1, 8'd255, 32'hFFFF_FFFF);
      wait_until_drained();
      write_thresholds(8'd10, 8'd20);
      send_item(lsp_pkg::MODE_WRITE, 6'd1, 1'b1, 8'd9, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd1, 1'b1, 8'd21, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd1, 1'b0, 8'd10, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd2, 1'b1, 8'd20, 32'd0);
      // With the minimum above the maximum no ticket count can pass.
      wait_until_drained();
      write_thresholds(8'd200, 8'd100);
      send_item(lsp_pkg::MODE_WRITE, 6'd4, 1'b1, 8'd150, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd4, 1'b1, 8'd200, 32'd0);
      wait_until_drained();
      write_thresholds(8'd0, 8'd255);
      send_item(lsp_pkg::MODE_WRITE, 6'd3, 1'b1, 8'd0, 32'd0);
   endtask

   task automatic test_draw_cases();
      send_item(lsp_pkg::MODE_WRITE, 6'd5, 1'b1, 8'd0, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd6, 1'b1, 8'd3, 32'd0);
      send_item(lsp_pkg::MODE_WRITE, 6'd7, 1'b0, 8'd100, 32'd0);
      // Runnable tickets are now 1, 20, 3 and 255 for a sum of 279.
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'd0);
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'd277);
      // A remainder equal to a running total must move on to the next slot.
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'd20);
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'hFFFF_FFFF);
      // Only runnable slots with zero tickets remain.
      send_item(lsp_pkg::MODE_DRAW, 6'd0, 1'b0, 8'd0, 32'd5);
   endtask

   task automatic test_random_traffic();
      int unsigned lo_roll;
      int unsigned hi_roll;
      lo_roll = $urandom_range(0, 255);
      hi_roll = $urandom_range(0, 255);
      run_random_phase(lsp_pkg::MIN_TICKETS_RESET, lsp_pkg::MAX_TICKETS_RESET, 200);
      run_random_phase(8'd0, 8'd255, 150);
      run_random_phase(8'd0, 8'd0, 40);
      run_random_phase(8'd255, 8'd255, 60);
      run_random_phase(8'd40, 8'd90, 120);
      run_random_phase(8'd180, 8'd60, 40);
      run_random_phase(lo_roll[lsp_pkg::CSR_DAT_W-1:0], hi_roll[lsp_pkg::CSR_DAT_W-1:0], 120);
      wait_until_drained();
      idling_on <= 1'b0;
      run_random_phase(lsp_pkg::MIN_TICKETS_RESET, lsp_pkg::MAX_TICKETS_RESET, 80);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_ticket_bounds();
      test_draw_cases();
      test_random_traffic();
      wait_until_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d slot writes (%0d rejected for tickets) and %0d draws.",
               accepted_writes + rejected_writes, rejected_writes, draw_count);
      $display("Draws produced %0d winners and %0d empty results over %0d cycles.",
               winner_count, empty_draws, cycle_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
